>>> hw/rtl/rcl_pkg.sv
// Shared types, codes and constants of the reliable command link.
package rcl_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_RES = 11;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(QUEUE_DEPTH + 5);
  localparam int AW = 5;

  localparam logic [31:0] SEQ_RESET = 32'd1;
  localparam logic [15:0] BEAT_RESET = 16'd500;
  localparam logic [15:0] LINK_RESET = 16'd2000;
  localparam logic [15:0] REPLY_RESET = 16'd2000;
  localparam logic [19:0] RUN_RESET = 20'd20000;
  localparam logic [19:0] START_RESET = 20'd180000;
  localparam logic [39:0] STATUS_IDLE = 40'h00_0000_FF00;
  localparam logic [7:0] GOOD_LEN = 8'd5;

  localparam logic [2:0] REG_INIT_SEQ = 3'd0;
  localparam logic [2:0] REG_BEAT = 3'd1;
  localparam logic [2:0] REG_LINK = 3'd2;
  localparam logic [2:0] REG_REPLY = 3'd3;
  localparam logic [2:0] REG_RUN = 3'd4;
  localparam logic [2:0] REG_START = 3'd5;

  localparam logic [1:0] OPC_TICK = 2'd0;
  localparam logic [1:0] OPC_SUBMIT = 2'd1;
  localparam logic [1:0] OPC_REPLY = 2'd2;
  localparam logic [1:0] OPC_STATUS = 2'd3;

  localparam logic [2:0] CMD_ARM = 3'd3;
  localparam logic [2:0] CMD_START = 3'd4;
  localparam logic [2:0] CMD_STOP = 3'd5;
  localparam logic [2:0] CMD_RESET = 3'd6;
  localparam logic [2:0] CMD_UNKNOWN = 3'd7;

  localparam logic [2:0] OP_SELECT = 3'd0;
  localparam logic [2:0] OP_ARM = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_STOP = 3'd3;
  localparam logic [2:0] OP_RESET = 3'd4;

  localparam logic [3:0] RC_TAKEN = 4'd0;
  localparam logic [3:0] RC_OK = 4'd1;
  localparam logic [3:0] RC_BUSY = 4'd2;
  localparam logic [3:0] RC_ABORTED = 4'd5;
  localparam logic [3:0] RC_UNKNOWN = 4'd7;
  localparam logic [3:0] RC_OFFLINE = 4'd8;
  localparam logic [3:0] RC_TIMEOUT = 4'd9;
  localparam logic [7:0] RC_LAST_VALID = 8'd5;

  localparam logic [1:0] KIND_REQ = 2'd0;
  localparam logic [1:0] KIND_BEAT = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  typedef struct packed {
    logic [31:0] seq;
    logic [2:0]  op;
    logic [1:0]  mode;
    logic [7:0]  tag;
    logic        tag_valid;
  } cmd_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [2:0]  op;
    logic [1:0]  mode;
    logic [7:0]  tag;
    logic        tag_valid;
    logic [3:0]  report_code;
    logic        link_alive;
    logic [39:0] status_word;
  } result_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_TICK, DP_EVAL, DP_HB, DP_DEAD, DP_TIMEOUT, DP_CANCEL_ONE,
    DP_CANCEL_END, DP_AUTOSTOP, DP_RESEND, DP_POP, DP_SUBMIT, DP_REP_NEW,
    DP_ENQUEUE, DP_CANCEL_PEND, DP_LAUNCH_NEW, DP_RX, DP_ACCEPT, DP_FINISH,
    DP_STATUS, DP_FLUSH
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_T_EVAL, ST_T_HB, ST_T_DEAD, ST_T_TO, ST_T_STOP,
    ST_T_POP, ST_S_CHECK, ST_S_PEND, ST_S_LAUNCH, ST_R_ACT, ST_CANCEL, ST_FLUSH
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] code;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] command;
    logic       len_ok;
    logic       match;
    logic       code_valid;
    logic       code_accept;
    logic       code_ok;
    logic       hb;
    logic       dead;
    logic       timeout;
    logic       moving;
    logic       resend;
    logic       launch_ok;
    logic       active;
    logic       accepted;
    logic       pend_start;
    logic       cnt_done;
    logic       full;
    logic       offline;
    logic       emit_ok;
    logic       hold_v;
  } dp_stat_t;

  function automatic result_t mk_req(cmd_entry_t c);
    result_t r;
    r = '0;
    r.kind = KIND_REQ;
    r.seq = c.seq;
    r.op = c.op;
    r.mode = c.mode;
    return r;
  endfunction

  function automatic result_t mk_rep(cmd_entry_t c, logic [3:0] code);
    result_t r;
    r = '0;
    r.kind = KIND_REPORT;
    r.seq = c.seq;
    r.op = c.op;
    r.mode = c.mode;
    r.tag = c.tag;
    r.tag_valid = c.tag_valid;
    r.report_code = code;
    return r;
  endfunction

endpackage

>>> hw/rtl/rcl_in_if.sv
// Input channel of the link: events, submits and received frames.
interface rcl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  command;
  logic [7:0]  cmd_tag;
  logic        has_tag;
  logic [7:0]  frame_len;
  logic [31:0] reply_seq;
  logic [7:0]  reply_code;
  logic [39:0] status_payload;

  modport source (output valid, opcode, command, cmd_tag, has_tag, frame_len, reply_seq,
                  reply_code, status_payload, input ready);
  modport sink (input valid, opcode, command, cmd_tag, has_tag, frame_len, reply_seq,
                reply_code, status_payload, output ready);
endinterface

>>> hw/rtl/rcl_out_if.sv
// Result channel of the link: frames to send, reports and status updates.
interface rcl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] seq;
  logic [2:0]  op;
  logic [1:0]  mode;
  logic [7:0]  tag;
  logic        tag_valid;
  logic [3:0]  report_code;
  logic        link_alive;
  logic [39:0] status_word;
  logic        last;

  modport source (output valid, kind, seq, op, mode, tag, tag_valid, report_code,
                  link_alive, status_word, last, input ready);
  modport sink (input valid, kind, seq, op, mode, tag, tag_valid, report_code,
                link_alive, status_word, last, output ready);
endinterface

>>> hw/rtl/rcl_ctrl.sv
// Controller state machine that sequences the datapath for each input word.
module rcl_ctrl
  import rcl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t st,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op = DP_NOP;
    cmd.code = RC_TAKEN;
    in_ready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_LOAD;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (st.opcode)
          OPC_TICK: begin
            cmd.op = DP_TICK;
            state_nxt = ST_T_EVAL;
          end
          OPC_SUBMIT: begin
            cmd.op = DP_SUBMIT;
            state_nxt = ST_S_CHECK;
          end
          OPC_REPLY: begin
            if (st.len_ok) cmd.op = DP_RX;
            state_nxt = st.len_ok ? ST_R_ACT : ST_FLUSH;
          end
          default: begin
            if (st.len_ok) cmd.op = DP_STATUS;
            state_nxt = ST_FLUSH;
          end
        endcase
      end
      ST_T_EVAL: begin
        cmd.op = DP_EVAL;
        state_nxt = ST_T_HB;
      end
      ST_T_HB: begin
        if (st.hb) cmd.op = DP_HB;
        state_nxt = ST_T_DEAD;
      end
      ST_T_DEAD: begin
        if (st.dead) cmd.op = DP_DEAD;
        state_nxt = ST_T_TO;
      end
      ST_T_TO: begin
        if (st.timeout) begin
          cmd.op = DP_TIMEOUT;
          state_nxt = ST_CANCEL;
        end else begin
          if (st.resend) cmd.op = DP_RESEND;
          state_nxt = ST_T_POP;
        end
      end
      ST_T_STOP: begin
        if (st.moving) cmd.op = DP_AUTOSTOP;
        state_nxt = ST_T_POP;
      end
      ST_T_POP: begin
        if (st.launch_ok) cmd.op = DP_POP;
        state_nxt = ST_FLUSH;
      end
      ST_S_CHECK: begin
        state_nxt = ST_FLUSH;
        if (st.command == CMD_UNKNOWN) begin
          cmd.op = DP_REP_NEW;
          cmd.code = RC_UNKNOWN;
        end else if (st.command == CMD_STOP || st.command == CMD_RESET) begin
          state_nxt = ST_CANCEL;
        end else if (st.offline) begin
          cmd.op = DP_REP_NEW;
          cmd.code = RC_OFFLINE;
        end else if ((st.active && st.pend_start) || st.full) begin
          cmd.op = DP_REP_NEW;
          cmd.code = RC_BUSY;
        end else begin
          cmd.op = DP_ENQUEUE;
        end
      end
      ST_S_PEND: begin
        if (st.active) cmd.op = DP_CANCEL_PEND;
        state_nxt = ST_S_LAUNCH;
      end
      ST_S_LAUNCH: begin
        cmd.op = DP_LAUNCH_NEW;
        state_nxt = ST_FLUSH;
      end
      ST_R_ACT: begin
        state_nxt = ST_FLUSH;
        if (st.match && st.code_valid) begin
          if (st.code_accept) begin
            if (!st.accepted) cmd.op = DP_ACCEPT;
          end else begin
            cmd.op = DP_FINISH;
            if (!st.code_ok) state_nxt = ST_CANCEL;
          end
        end
      end
      ST_CANCEL: begin
        if (!st.cnt_done) begin
          cmd.op = DP_CANCEL_ONE;
        end else begin
          cmd.op = DP_CANCEL_END;
          case (st.opcode)
            OPC_TICK: state_nxt = ST_T_STOP;
            OPC_SUBMIT: state_nxt = ST_S_PEND;
            default: state_nxt = ST_FLUSH;
          endcase
        end
      end
      ST_FLUSH: begin
        if (st.hold_v) cmd.op = DP_FLUSH;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r != ST_IDLE && !st.emit_ok) begin
      cmd.op = DP_NOP;
      state_nxt = state_r;
    end
  end

endmodule

>>> hw/rtl/rcl_dpath.sv
// Datapath: link state, timers, command queue, registers and result staging.
module rcl_dpath
  import rcl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  rcl_in_if.sink            in_ch,
  rcl_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AW-1:0]     paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          st
);

  logic [31:0] init_seq_r, beat_r_unused_guard;
  logic [15:0] beat_r, link_r, reply_r;
  logic [19:0] run_r, start_r;

  logic [31:0] now_r, last_beat_r, last_rx_r, sent_at_r, began_at_r, seq_r;
  logic        active_r, accepted_r, seen_r;
  cmd_entry_t  pend_r, new_r;
  cmd_entry_t  q_r [QUEUE_DEPTH];
  logic [QW-1:0] head_r;
  logic [CW-1:0] count_r, idx_r;
  logic [39:0] store_r;

  logic [1:0]  opc_r;
  logic [2:0]  command_r;
  logic [7:0]  ctag_r, len_r, rcode_r;
  logic        htag_r;
  logic [31:0] rseq_r;
  logic [39:0] spay_r;

  logic alive_r, hb_r, dead_r, to_r, mov_r, rs_r;
  logic [NW-1:0] n_r;

  result_t hold_r, out_r;
  logic    hold_v_r, out_v_r, out_last_r;

  logic [2:0]  reg_idx;
  logic        wr_en;
  logic [CW:0] addr_sum, addr_wrap;
  logic [QW-1:0] q_addr, head_inc;
  cmd_entry_t  q_rd;
  logic        alive_c, hb_due_c, to_c, mov_c, rs_c, launch_c;
  logic [31:0] limit_c, s1_c, nseq_c;
  logic [NW-1:0] npred_c;
  result_t     res_c;
  logic        emit_c, do_emit, out_free;
  cmd_entry_t  stop_c, sub_c;

  assign beat_r_unused_guard = '0;
  assign reg_idx = paddr[AW-1:2];
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      REG_INIT_SEQ: prdata = init_seq_r;
      REG_BEAT: prdata = {16'd0, beat_r};
      REG_LINK: prdata = {16'd0, link_r};
      REG_REPLY: prdata = {16'd0, reply_r};
      REG_RUN: prdata = {12'd0, run_r};
      REG_START: prdata = {12'd0, start_r};
      default: prdata = beat_r_unused_guard;
    endcase
  end

  // Queue address: head plus an offset, wrapped at the depth.
  always_comb begin
    addr_sum = (CW+1)'(head_r) + (CW+1)'((cmd.op == DP_ENQUEUE) ? count_r : idx_r);
    addr_wrap = (addr_sum >= (CW+1)'(QUEUE_DEPTH)) ? addr_sum - (CW+1)'(QUEUE_DEPTH)
                                                   : addr_sum;
    q_addr = QW'(addr_wrap);
    q_rd = q_r[q_addr];
    head_inc = (32'(head_r) + 32'd1 >= 32'(QUEUE_DEPTH)) ? '0 : head_r + QW'(1);
  end

  always_comb begin
    alive_c = seen_r && ((now_r - last_rx_r) <= {16'd0, link_r});
    hb_due_c = (now_r - last_beat_r) >= {16'd0, beat_r};
    if (accepted_r) begin
      limit_c = (pend_r.op == OP_START) ? {12'd0, start_r} : {12'd0, run_r};
    end else begin
      limit_c = {16'd0, reply_r};
    end
    to_c = active_r && (((now_r - began_at_r) > limit_c) || (!alive_c && accepted_r));
    mov_c = (pend_r.op == OP_START) || (pend_r.op == OP_ARM);
    rs_c = active_r && !to_c && ((now_r - sent_at_r) >= {16'd0, beat_r});
    launch_c = !to_c && !active_r && (count_r != '0);
    npred_c = NW'(!alive_c && seen_r) + NW'(launch_c)
            + (to_c ? NW'(1) + NW'(count_r) + NW'(mov_c) : NW'(rs_c));
    s1_c = seq_r + 32'd1;
    nseq_c = (s1_c == 32'd0) ? 32'd1 : s1_c;
    stop_c = '0;
    stop_c.seq = s1_c;
    stop_c.op = OP_STOP;
    sub_c = '0;
    sub_c.seq = nseq_c;
    sub_c.tag = ctag_r;
    sub_c.tag_valid = htag_r;
    case (command_r)
      CMD_ARM: sub_c.op = OP_ARM;
      CMD_START: sub_c.op = OP_START;
      CMD_STOP: sub_c.op = OP_STOP;
      CMD_RESET: sub_c.op = OP_RESET;
      CMD_UNKNOWN: sub_c.op = OP_SELECT;
      default: sub_c.mode = command_r[1:0];
    endcase
  end

  always_comb begin
    res_c = '0;
    emit_c = 1'b1;
    case (cmd.op)
      DP_HB: res_c.kind = KIND_BEAT;
      DP_DEAD: begin
        res_c.kind = KIND_STATUS;
        res_c.status_word = store_r;
      end
      DP_STATUS: begin
        res_c.kind = KIND_STATUS;
        res_c.link_alive = 1'b1;
        res_c.status_word = spay_r;
      end
      DP_TIMEOUT: res_c = mk_rep(pend_r, RC_TIMEOUT);
      DP_CANCEL_ONE: res_c = mk_rep(q_rd, RC_ABORTED);
      DP_AUTOSTOP: res_c = mk_req(stop_c);
      DP_RESEND: res_c = mk_req(pend_r);
      DP_POP: res_c = alive_r ? mk_req(q_rd) : mk_rep(q_rd, RC_OFFLINE);
      DP_REP_NEW: res_c = mk_rep(new_r, cmd.code);
      DP_CANCEL_PEND: res_c = mk_rep(pend_r, RC_ABORTED);
      DP_LAUNCH_NEW: res_c = mk_req(new_r);
      DP_ACCEPT: res_c = mk_rep(pend_r, RC_TAKEN);
      DP_FINISH: res_c = mk_rep(pend_r, rcode_r[3:0]);
      default: emit_c = 1'b0;
    endcase
    out_free = !out_v_r || out_ch.ready;
    do_emit = emit_c && (n_r < NW'(MAX_RES));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_seq_r <= SEQ_RESET;
      beat_r <= BEAT_RESET;
      link_r <= LINK_RESET;
      reply_r <= REPLY_RESET;
      run_r <= RUN_RESET;
      start_r <= START_RESET;
      now_r <= '0;
      last_beat_r <= 32'd0 - {16'd0, BEAT_RESET};
      last_rx_r <= '0;
      sent_at_r <= '0;
      began_at_r <= '0;
      seq_r <= SEQ_RESET;
      active_r <= 1'b0;
      accepted_r <= 1'b0;
      seen_r <= 1'b0;
      pend_r <= '0;
      head_r <= '0;
      count_r <= '0;
      idx_r <= '0;
      store_r <= STATUS_IDLE;
      n_r <= '0;
      hold_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (wr_en) begin
        case (reg_idx)
          REG_INIT_SEQ: begin
            init_seq_r <= pwdata;
            seq_r <= (pwdata == 32'd0) ? 32'd1 : pwdata;
          end
          REG_BEAT: beat_r <= pwdata[15:0];
          REG_LINK: link_r <= pwdata[15:0];
          REG_REPLY: reply_r <= pwdata[15:0];
          REG_RUN: run_r <= pwdata[19:0];
          REG_START: start_r <= pwdata[19:0];
          default: ;
        endcase
      end
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      if (do_emit) begin
        n_r <= n_r + NW'(1);
        hold_r <= res_c;
        hold_v_r <= 1'b1;
        if (hold_v_r) begin
          out_r <= hold_r;
          out_last_r <= 1'b0;
          out_v_r <= 1'b1;
        end
      end
      case (cmd.op)
        DP_LOAD: begin
          n_r <= '0;
          opc_r <= in_ch.opcode;
          command_r <= in_ch.command;
          ctag_r <= in_ch.cmd_tag;
          htag_r <= in_ch.has_tag;
          len_r <= in_ch.frame_len;
          rseq_r <= in_ch.reply_seq;
          rcode_r <= in_ch.reply_code;
          spay_r <= in_ch.status_payload;
        end
        DP_TICK: now_r <= now_r + 32'd1;
        DP_EVAL: begin
          alive_r <= alive_c;
          hb_r <= hb_due_c && (npred_c < NW'(MAX_RES));
          dead_r <= !alive_c && seen_r;
          to_r <= to_c;
          mov_r <= mov_c;
          rs_r <= rs_c;
        end
        DP_HB: last_beat_r <= now_r;
        DP_DEAD: seen_r <= 1'b0;
        DP_TIMEOUT: active_r <= 1'b0;
        DP_CANCEL_ONE: idx_r <= idx_r + CW'(1);
        DP_CANCEL_END: begin
          idx_r <= '0;
          count_r <= '0;
          head_r <= '0;
        end
        DP_AUTOSTOP: begin
          seq_r <= s1_c;
          pend_r <= stop_c;
          active_r <= 1'b1;
          accepted_r <= 1'b0;
          began_at_r <= now_r;
          sent_at_r <= now_r;
        end
        DP_RESEND: sent_at_r <= now_r;
        DP_POP: begin
          head_r <= head_inc;
          count_r <= count_r - CW'(1);
          if (alive_r) begin
            pend_r <= q_rd;
            active_r <= 1'b1;
            accepted_r <= 1'b0;
            began_at_r <= now_r;
            sent_at_r <= now_r;
          end
        end
        DP_SUBMIT: begin
          seq_r <= nseq_c;
          new_r <= sub_c;
        end
        DP_ENQUEUE: begin
          q_r[q_addr] <= new_r;
          count_r <= count_r + CW'(1);
        end
        DP_LAUNCH_NEW: begin
          pend_r <= new_r;
          active_r <= 1'b1;
          accepted_r <= 1'b0;
          began_at_r <= now_r;
          sent_at_r <= now_r;
        end
        DP_RX: last_rx_r <= now_r;
        DP_ACCEPT: accepted_r <= 1'b1;
        DP_FINISH: active_r <= 1'b0;
        DP_STATUS: begin
          store_r <= spay_r;
          last_rx_r <= now_r;
          seen_r <= 1'b1;
        end
        DP_FLUSH: begin
          out_r <= hold_r;
          out_last_r <= 1'b1;
          out_v_r <= 1'b1;
          hold_v_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st.opcode = opc_r;
    st.command = command_r;
    st.len_ok = (len_r == GOOD_LEN);
    st.match = active_r && (rseq_r == pend_r.seq);
    st.code_valid = (rcode_r <= RC_LAST_VALID);
    st.code_accept = (rcode_r == {4'd0, RC_TAKEN});
    st.code_ok = (rcode_r == {4'd0, RC_OK});
    st.hb = hb_r;
    st.dead = dead_r;
    st.timeout = to_r;
    st.moving = mov_r;
    st.resend = rs_r;
    st.launch_ok = !active_r && (count_r != '0);
    st.active = active_r;
    st.accepted = accepted_r;
    st.pend_start = (pend_r.op == OP_START);
    st.cnt_done = (idx_r == count_r);
    st.full = (count_r >= CW'(QUEUE_DEPTH));
    st.offline = !seen_r || ((now_r - last_rx_r) > {16'd0, link_r});
    st.emit_ok = !hold_v_r || out_free;
    st.hold_v = hold_v_r;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.kind = out_r.kind;
  assign out_ch.seq = out_r.seq;
  assign out_ch.op = out_r.op;
  assign out_ch.mode = out_r.mode;
  assign out_ch.tag = out_r.tag;
  assign out_ch.tag_valid = out_r.tag_valid;
  assign out_ch.report_code = out_r.report_code;
  assign out_ch.link_alive = out_r.link_alive;
  assign out_ch.status_word = out_r.status_word;
  assign out_ch.last = out_last_r;

endmodule

>>> hw/rtl/reliable_command_link_unit.sv
// Top level of the reliable command link: controller, datapath and ports.
//
//   Channel   Direction  Handshake             Carries
//   in_ch     in         valid/ready           tick, submit, reply or status word
//   out_ch    out        valid/ready           request, heartbeat, report, status
//   APB       in         psel/penable/pwrite   six configuration registers
//
// A tick that times out a command with a full queue takes longest from acceptance to
// the next ready, since the queue is walked one entry per cycle while the result side
// does not stall.
// Results leave through a one-entry staging register and an output register,
// so an output stall holds the controller without losing results.
// Reset is synchronous and active low; no clearing pass is needed.
module reliable_command_link_unit
  import rcl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  rcl_in_if.sink        in_ch,
  rcl_out_if.source     out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;
  logic     in_rdy;

  assign pready = 1'b1;
  assign in_ch.ready = in_rdy;

  rcl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .st       (dp_stat),
    .cmd      (ctl_cmd)
  );

  rcl_dpath u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cmd     (ctl_cmd),
    .st      (dp_stat)
  );

endmodule

>>> tb/tb_reliable_command_link_unit.sv
// Testbench of the reliable command link: random and directed words checked against a predictor.
`timescale 1ns / 1ps

module tb_reliable_command_link_unit;
  import rcl_pkg::*;

  localparam logic [2:0] CMD_PRESS = 3'd0;
  localparam logic [2:0] CMD_RUB = 3'd1;
  localparam logic [2:0] CMD_SLIDE = 3'd2;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic [1:0]  opcode;
    logic [2:0]  command;
    logic [7:0]  cmd_tag;
    logic        has_tag;
    logic [7:0]  frame_len;
    logic [31:0] reply_seq;
    logic [7:0]  reply_code;
    logic [39:0] status_payload;
  } link_word_t;

  typedef struct {
    result_t r;
    logic    last;
  } link_result_t;

  class link_scoreboard;
    logic [31:0] init_seq, beat_ms, link_ms, reply_ms, run_ms, start_ms;
    logic [31:0] now_ms, last_beat, last_rx, sent_at, began_at, seq_ctr;
    logic active, accepted, seen;
    cmd_entry_t pend;
    cmd_entry_t fifo[QUEUE_DEPTH];
    int qcnt;
    logic [39:0] status_store;
    result_t outbuf[$];
    link_result_t expected[$];
    int errors;

    function new();
      errors = 0;
      init_seq = SEQ_RESET;
      beat_ms = BEAT_RESET;
      link_ms = LINK_RESET;
      reply_ms = REPLY_RESET;
      run_ms = RUN_RESET;
      start_ms = START_RESET;
      now_ms = 0;
      last_beat = 32'd0 - beat_ms;
      last_rx = 0;
      sent_at = 0;
      began_at = 0;
      seq_ctr = init_seq;
      active = 0;
      accepted = 0;
      seen = 0;
      pend = '0;
      qcnt = 0;
      status_store = STATUS_IDLE;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_INIT_SEQ: begin
          init_seq = val;
          seq_ctr = (val == 0) ? 32'd1 : val;
        end
        REG_BEAT: beat_ms = 32'(val[15:0]);
        REG_LINK: link_ms = 32'(val[15:0]);
        REG_REPLY: reply_ms = 32'(val[15:0]);
        REG_RUN: run_ms = 32'(val[19:0]);
        REG_START: start_ms = 32'(val[19:0]);
        default: ;
      endcase
    endfunction

    function void add(result_t r);
      if (outbuf.size() < QUEUE_DEPTH + 4) outbuf.push_back(r);
    endfunction

    function void send_frame();
      result_t r;
      r = '0;
      r.kind = KIND_REQ;
      r.seq = pend.seq;
      r.op = pend.op;
      r.mode = pend.mode;
      add(r);
      sent_at = now_ms;
    endfunction

    function void report(cmd_entry_t c, logic [3:0] code);
      result_t r;
      r = '0;
      r.kind = KIND_REPORT;
      r.seq = c.seq;
      r.op = c.op;
      r.mode = c.mode;
      r.tag = c.tag;
      r.tag_valid = c.tag_valid;
      r.report_code = code;
      add(r);
    endfunction

    function void status_note(logic alive);
      result_t r;
      r = '0;
      r.kind = KIND_STATUS;
      r.link_alive = alive;
      r.status_word = status_store;
      add(r);
    endfunction

    function void cancel_all();
      for (int i = 0; i < qcnt; i++) report(fifo[i], RC_ABORTED);
      qcnt = 0;
    endfunction

    function void launch(cmd_entry_t c);
      pend = c;
      active = 1;
      accepted = 0;
      began_at = now_ms;
      send_frame();
    endfunction

    function void tick();
      logic [31:0] limit;
      logic hb_due, alive, moving;
      cmd_entry_t c;
      result_t hb;
      now_ms = now_ms + 1;
      hb_due = (now_ms - last_beat) >= beat_ms;
      alive = seen && ((now_ms - last_rx) <= link_ms);
      if (!alive && seen) begin
        seen = 0;
        status_note(1'b0);
      end
      if (active) begin
        limit = accepted ? ((pend.op == OP_START) ? start_ms : run_ms) : reply_ms;
        if ((now_ms - began_at) > limit || (!alive && accepted)) begin
          moving = (pend.op == OP_START) || (pend.op == OP_ARM);
          report(pend, RC_TIMEOUT);
          active = 0;
          cancel_all();
          if (moving) begin
            c = '0;
            seq_ctr = seq_ctr + 1;
            c.seq = seq_ctr;
            c.op = OP_STOP;
            launch(c);
          end
        end else if ((now_ms - sent_at) >= beat_ms) begin
          send_frame();
        end
      end
      if (!active && qcnt > 0) begin
        c = fifo[0];
        for (int i = 0; i < qcnt - 1; i++) fifo[i] = fifo[i + 1];
        qcnt--;
        if (alive) launch(c);
        else report(c, RC_OFFLINE);
      end
      if (hb_due && outbuf.size() < MAX_RES) begin
        hb = '0;
        hb.kind = KIND_BEAT;
        outbuf.push_front(hb);
        last_beat = now_ms;
      end
    endfunction

    function void submit(logic [2:0] command, logic [7:0] tag, logic has_tag);
      cmd_entry_t c;
      c = '0;
      seq_ctr = seq_ctr + 1;
      if (seq_ctr == 0) seq_ctr = seq_ctr + 1;
      c.seq = seq_ctr;
      c.tag = tag;
      c.tag_valid = has_tag;
      case (command)
        CMD_PRESS, CMD_RUB, CMD_SLIDE: begin
          c.op = OP_SELECT;
          c.mode = command[1:0];
        end
        CMD_ARM: c.op = OP_ARM;
        CMD_START: c.op = OP_START;
        CMD_STOP: c.op = OP_STOP;
        CMD_RESET: c.op = OP_RESET;
        default: begin
          report(c, RC_UNKNOWN);
          return;
        end
      endcase
      if (c.op == OP_STOP || c.op == OP_RESET) begin
        cancel_all();
        if (active) report(pend, RC_ABORTED);
        launch(c);
      end else if (!seen || (now_ms - last_rx) > link_ms) begin
        report(c, RC_OFFLINE);
      end else if (active && pend.op == OP_START) begin
        report(c, RC_BUSY);
      end else if (qcnt >= QUEUE_DEPTH) begin
        report(c, RC_BUSY);
      end else begin
        fifo[qcnt] = c;
        qcnt++;
      end
    endfunction

    function void reply(logic [31:0] rseq, logic [7:0] code);
      last_rx = now_ms;
      if (!active || rseq != pend.seq || code > RC_LAST_VALID) return;
      if (code == RC_TAKEN) begin
        if (!accepted) report(pend, RC_TAKEN);
        accepted = 1;
      end else begin
        report(pend, code[3:0]);
        active = 0;
        if (code != RC_OK) cancel_all();
      end
    endfunction

    function void note_word(link_word_t w);
      link_result_t e;
      int n;
      outbuf.delete();
      case (w.opcode)
        OPC_TICK: tick();
        OPC_SUBMIT: submit(w.command, w.cmd_tag, w.has_tag);
        OPC_REPLY: if (w.frame_len == GOOD_LEN) reply(w.reply_seq, w.reply_code);
        default: if (w.frame_len == GOOD_LEN) begin
          status_store = w.status_payload;
          last_rx = now_ms;
          seen = 1;
          status_note(1'b1);
        end
      endcase
      n = (outbuf.size() < MAX_RES) ? outbuf.size() : MAX_RES;
      for (int k = 0; k < n; k++) begin
        e.r = outbuf[k];
        e.last = (k == n - 1);
        expected.push_back(e);
      end
    endfunction

    function void field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(result_t got, logic got_last);
      link_result_t e;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual kind %0d seq %0h",
                 $time, got.kind, got.seq);
        return;
      end
      e = expected.pop_front();
      field("kind", e.r.kind, got.kind);
      field("seq", e.r.seq, got.seq);
      field("op", e.r.op, got.op);
      field("mode", e.r.mode, got.mode);
      field("tag", e.r.tag, got.tag);
      field("tag_valid", e.r.tag_valid, got.tag_valid);
      field("report_code", e.r.report_code, got.report_code);
      field("link_alive", e.r.link_alive, got.link_alive);
      field("status_word", e.r.status_word, got.status_word);
      field("last", e.last, got_last);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic no_idle;
  int cycles;
  link_scoreboard sb;

  rcl_in_if in_ch ();
  rcl_out_if out_ch ();

  reliable_command_link_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    result_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[reliable_command_link_unit] ERROR");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '0;
      got.kind = out_ch.kind;
      got.seq = out_ch.seq;
      got.op = out_ch.op;
      got.mode = out_ch.mode;
      got.tag = out_ch.tag;
      got.tag_valid = out_ch.tag_valid;
      got.report_code = out_ch.report_code;
      got.link_alive = out_ch.link_alive;
      got.status_word = out_ch.status_word;
      sb.check_result(got, out_ch.last);
    end
    out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 13);
  end

  function automatic link_word_t make_word(logic [1:0] opc, logic [2:0] cmd, logic [7:0] tag,
                                           logic htag, logic [7:0] len, logic [31:0] rseq,
                                           logic [7:0] rcode, logic [39:0] payload);
    link_word_t w;
    w.opcode = opc;
    w.command = cmd;
    w.cmd_tag = tag;
    w.has_tag = htag;
    w.frame_len = len;
    w.reply_seq = rseq;
    w.reply_code = rcode;
    w.status_payload = payload;
    return w;
  endfunction

  task automatic send_word(link_word_t w);
    if (!no_idle) begin
      while ($urandom_range(99) < 13) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= w.opcode;
    in_ch.command <= w.command;
    in_ch.cmd_tag <= w.cmd_tag;
    in_ch.has_tag <= w.has_tag;
    in_ch.frame_len <= w.frame_len;
    in_ch.reply_seq <= w.reply_seq;
    in_ch.reply_code <= w.reply_code;
    in_ch.status_payload <= w.status_payload;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic send_tick();
    send_word(make_word(OPC_TICK, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic send_cmd(logic [2:0] cmd, logic [7:0] tag, logic htag);
    send_word(make_word(OPC_SUBMIT, cmd, tag, htag, 0, 0, 0, 0));
  endtask

  task automatic send_reply(logic [31:0] rseq, logic [7:0] code);
    send_word(make_word(OPC_REPLY, 0, 0, 0, GOOD_LEN, rseq, code, 0));
  endtask

  task automatic send_status(logic [39:0] payload);
    send_word(make_word(OPC_STATUS, 0, 0, 0, GOOD_LEN, 0, 0, payload));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Back-to-back writes keep psel high; the caller closes the transfer.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AW'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(logic [31:0] seq0, logic [15:0] beat, logic [15:0] link,
                            logic [15:0] rto, logic [19:0] run, logic [19:0] start);
    wait_drained();
    write_reg(REG_INIT_SEQ, seq0);
    write_reg(REG_BEAT, 32'(beat));
    write_reg(REG_LINK, 32'(link));
    write_reg(REG_REPLY, 32'(rto));
    write_reg(REG_RUN, 32'(run));
    write_reg(REG_START, 32'(start));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic link_word_t random_word();
    link_word_t w;
    int pick;
    pick = $urandom_range(99);
    w.opcode = (pick < 40) ? OPC_TICK : (pick < 62) ? OPC_SUBMIT :
               (pick < 82) ? OPC_REPLY : OPC_STATUS;
    w.command = 3'($urandom_range(15));
    if ($urandom_range(15) >= 8) w.command = 3'($urandom_range(2));
    w.cmd_tag = 8'($urandom_range(255));
    w.has_tag = 1'($urandom_range(1));
    w.frame_len = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : GOOD_LEN;
    w.reply_seq = (sb.active && $urandom_range(99) < 85) ? sb.pend.seq : $urandom;
    w.reply_code = 8'($urandom_range(6));
    if (w.reply_code == 8'd6) w.reply_code = 8'(RC_TAKEN);
    if ($urandom_range(9) == 0) w.reply_code = 8'($urandom_range(255));
    w.status_payload = {8'($urandom), 32'($urandom)};
    return w;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  initial begin
    sb = new();
    cycles = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OPC_TICK;
    in_ch.command = '0;
    in_ch.cmd_tag = '0;
    in_ch.has_tag = 1'b0;
    in_ch.frame_len = '0;
    in_ch.reply_seq = '0;
    in_ch.reply_code = '0;
    in_ch.status_payload = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(make_word(OPC_STATUS, 0, 0, 0, 8'd255, 0, 0, '1));
    send_tick();
    send_cmd(CMD_UNKNOWN, 8'd255, 1'b1);
    send_cmd(CMD_PRESS, 8'd0, 1'b1);
    send_status('0);
    send_status('1);
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) send_cmd(3'(i % 4), 8'(i), 1'b1);
    send_tick();
    send_reply(sb.pend.seq + 1, 8'(RC_TAKEN));
    send_reply(sb.pend.seq, 8'd255);
    send_reply(sb.pend.seq, 8'(RC_TAKEN));
    send_reply(sb.pend.seq, 8'(RC_TAKEN));
    send_reply(sb.pend.seq, 8'(RC_OK));
    send_tick();
    send_reply(sb.pend.seq, 8'(RC_BUSY));
    send_cmd(CMD_START, 8'd7, 1'b0);
    send_tick();
    send_reply(sb.pend.seq, 8'(RC_TAKEN));
    send_cmd(CMD_SLIDE, 8'd9, 1'b1);
    send_word(make_word(OPC_REPLY, 0, 0, 0, 8'd4, sb.pend.seq, 8'(RC_OK), 0));
    send_cmd(CMD_STOP, 8'd1, 1'b1);
    send_cmd(CMD_RESET, 8'd2, 1'b0);
    send_reply(32'hFFFF_FFFF, 8'(RC_ABORTED));

    set_config(32'hFFFF_FFFE, 16'd1, 16'd1, 16'd1, 20'd1, 20'd1);
    send_status('1);
    send_cmd(CMD_ARM, 8'd3, 1'b1);
    repeat (4) send_tick();
    run_random(100);

    set_config(32'd0, 16'd4, 16'd30, 16'd12, 20'd20, 20'd40);
    no_idle = 1'b1;
    run_random(60);
    no_idle = 1'b0;
    run_random(90);
    wait_drained();
    run_random(20);

    set_config($urandom, 16'd65535, 16'd65535, 16'd65535, 20'hFFFFF, 20'hFFFFF);
    run_random(70);

    set_config(32'hFFFF_FFFF, 16'd7, 16'd25, 16'd15, 20'd30, 20'd60);
    run_random(45);

    wait_drained();
    if (sb.errors == 0) begin
      $display("[reliable_command_link_unit] OK");
    end else begin
      $display("[reliable_command_link_unit] ERROR");
    end
    $finish;
  end

endmodule
